/* design/interval_set_membership_table_assert.svh */
// assertion macros shared by the interval set table
`ifndef INTERVAL_SET_MEMBERSHIP_TABLE_ASSERT_SVH
`define INTERVAL_SET_MEMBERSHIP_TABLE_ASSERT_SVH

// expression holds at every clock edge out of reset
`define ISMS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("interval set table check failed");

// consequence holds in the same cycle as the antecedent
`define ISMS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval set table check failed");

// consequence holds in the cycle after the antecedent
`define ISMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval set table check failed");

`endif

/* design/isms_pkg.sv */
// package: types and codes of the interval set table
`timescale 1ns / 1ps
`default_nettype none

package isms_pkg;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NO   = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_RD_PREV,
        S_RD_NEXT,
        S_GRAB,
        S_DECIDE,
        S_SHIFT,
        S_FIX,
        S_REPLY
    } state_t;

    // one stored interval, lo in the low half
    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } entry_t;

    localparam int ENTRY_W = 64;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

endpackage

`default_nettype wire

/* design/isms_req_if.sv */
// interface: request channel carrying one operation item
`timescale 1ns / 1ps
`default_nettype none

interface isms_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

/* design/isms_rsp_if.sv */
// interface: response channel carrying one result item
`timescale 1ns / 1ps
`default_nettype none

interface isms_rsp_if;
    logic                 valid;
    logic                 ready;
    isms_pkg::status_t    status;
    logic [32:0]          member_total;
    logic [6:0]           interval_total;

    modport source (output valid, output status, output member_total,
                    output interval_total, input ready);
    modport sink   (input valid, input status, input member_total,
                    input interval_total, output ready);
endinterface

`default_nettype wire

/* design/isms_ram.sv */
// generic ram: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module isms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/interval_set_membership_table.sv */
// top level: sorted interval set with member and interval counts
//
// usage
//   request carries one item (operation, value); response carries one item
//   (status, member_total, interval_total) per request, in order
//   operation: query, insert or erase; code 3 acts as a query
//   intervals live in one ram, sorted by lo; a binary search finds the
//   number p of intervals with lo <= value, then the two neighbors p-1 and p
//   are read and the update is decided
//   an insert or erase that adds or drops an interval also moves up to n
//   entries (n stored intervals), one entry per cycle over the ram ports
//   one item at a time: request is ready only while no item is in work
//   a finished result waits in the output register; the next request is
//   taken while it waits, and the block stalls before writing a new result
//   until the receiver takes the old one
//   reset clears the counts, so the set is empty; no clearing pass, since
//   only entries below the interval count are ever read
`timescale 1ns / 1ps
`default_nettype none

module interval_set_membership_table #(
    parameter int MAX_INTERVALS = 64
) (
    input wire logic   clk,
    input wire logic   rst_n,
    isms_req_if.sink   request,
    isms_rsp_if.source response
);

    `include "interval_set_membership_table_assert.svh"

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = $clog2(MAX_INTERVALS);

    // control state
    isms_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [32:0]       member_reg, member_next;
    logic              out_valid_reg, out_valid_next;
    logic              pend_reg, pend_next;
    logic              late_we_reg, late_we_next;

    // work registers
    logic [1:0]           op_reg, op_next;
    logic signed [31:0]   x_reg, x_next;
    logic [CW-1:0]        a_reg, a_next;
    logic [CW-1:0]        b_reg, b_next;
    logic [CW-1:0]        mid_reg, mid_next;
    isms_pkg::entry_t     prev_reg, prev_next;
    isms_pkg::entry_t     next_reg, next_next;
    logic                 have_prev_reg, have_prev_next;
    logic                 have_next_reg, have_next_next;
    logic [CW-1:0]        src_reg, src_next;
    logic [CW-1:0]        moves_reg, moves_next;
    logic                 dir_up_reg, dir_up_next;
    logic [AW-1:0]        pend_dst_reg, pend_dst_next;
    logic [AW-1:0]        late_addr_reg, late_addr_next;
    isms_pkg::entry_t     late_data_reg, late_data_next;
    // status of the item in work, kept apart from the waiting result
    isms_pkg::status_t    verdict_reg, verdict_next;

    // output register
    isms_pkg::status_t    status_reg, status_next;
    logic [32:0]          out_member_reg, out_member_next;
    logic [6:0]           out_count_reg, out_count_next;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    isms_pkg::entry_t     ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [isms_pkg::ENTRY_W-1:0] ram_rdata;
    isms_pkg::entry_t     rd_entry;

    // decision terms
    logic [CW:0]          mid_sum;
    logic [CW-1:0]        p_dec;
    logic signed [31:0]   x_dec;
    logic signed [31:0]   x_inc;
    logic                 in_prev;
    logic                 ext_prev;
    logic                 ext_next;
    logic                 full;

    isms_ram #(
        .WIDTH (isms_pkg::ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = isms_pkg::entry_t'(ram_rdata);

    assign mid_sum = ({1'b0, a_reg} + {1'b0, b_reg}) >> 1;
    assign p_dec   = a_reg - CW'(1);
    assign x_dec   = x_reg - 32'sd1;
    assign x_inc   = x_reg + 32'sd1;

    // value lies in the interval just at or below it
    assign in_prev  = have_prev_reg && (prev_reg.hi >= x_reg);
    // neighbors touch the value; no wrap at the ends of the range
    assign ext_prev = have_prev_reg && (x_reg != isms_pkg::VALUE_MIN) && (prev_reg.hi == x_dec);
    assign ext_next = have_next_reg && (x_reg != isms_pkg::VALUE_MAX) && (next_reg.lo == x_inc);
    assign full     = (count_reg >= CW'(MAX_INTERVALS));

    assign request.ready           = (state_reg == isms_pkg::S_IDLE);
    assign response.valid          = out_valid_reg;
    assign response.status         = status_reg;
    assign response.member_total   = out_member_reg;
    assign response.interval_total = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        member_next     = member_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        pend_next       = pend_reg;
        late_we_next    = late_we_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        mid_next        = mid_reg;
        prev_next       = prev_reg;
        next_next       = next_reg;
        have_prev_next  = have_prev_reg;
        have_next_next  = have_next_reg;
        src_next        = src_reg;
        moves_next      = moves_reg;
        dir_up_next     = dir_up_reg;
        pend_dst_next   = pend_dst_reg;
        late_addr_next  = late_addr_reg;
        late_data_next  = late_data_reg;
        verdict_next    = verdict_reg;
        status_next     = status_reg;
        out_member_next = out_member_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = p_dec[AW-1:0];
        ram_wdata       = prev_reg;
        ram_re          = 1'b0;
        ram_raddr       = mid_sum[AW-1:0];

        unique case (state_reg)
            isms_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    op_next    = request.operation;
                    x_next     = request.value;
                    a_next     = '0;
                    b_next     = count_reg;
                    state_next = isms_pkg::S_SEARCH;
                end
            end

            // one binary search step: read the middle entry
            isms_pkg::S_SEARCH:
            begin
                if (a_reg < b_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid_sum[AW-1:0];
                    mid_next   = mid_sum[CW-1:0];
                    state_next = isms_pkg::S_CMP;
                end
                else
                begin
                    state_next = isms_pkg::S_RD_PREV;
                end
            end

            isms_pkg::S_CMP:
            begin
                if (rd_entry.lo <= x_reg)
                begin
                    a_next = mid_reg + CW'(1);
                end
                else
                begin
                    b_next = mid_reg;
                end
                state_next = isms_pkg::S_SEARCH;
            end

            // a_reg now holds p; fetch entries p-1 and p where they exist
            isms_pkg::S_RD_PREV:
            begin
                have_prev_next = (a_reg != '0);
                ram_re         = (a_reg != '0);
                ram_raddr      = p_dec[AW-1:0];
                state_next     = isms_pkg::S_RD_NEXT;
            end

            isms_pkg::S_RD_NEXT:
            begin
                if (have_prev_reg)
                begin
                    prev_next = rd_entry;
                end
                have_next_next = (a_reg < count_reg);
                ram_re         = (a_reg < count_reg);
                ram_raddr      = a_reg[AW-1:0];
                state_next     = isms_pkg::S_GRAB;
            end

            isms_pkg::S_GRAB:
            begin
                if (have_next_reg)
                begin
                    next_next = rd_entry;
                end
                state_next = isms_pkg::S_DECIDE;
            end

            // pick the update; in-place edits are written here, a moved
            // range goes through the shift states
            isms_pkg::S_DECIDE:
            begin
                verdict_next   = isms_pkg::STATUS_NO;
                state_next     = isms_pkg::S_REPLY;
                late_we_next   = 1'b0;
                late_addr_next = a_reg[AW-1:0];
                pend_next      = 1'b0;
                unique case (op_reg)
                    isms_pkg::OP_INSERT:
                    begin
                        priority if (in_prev)
                        begin
                            verdict_next = isms_pkg::STATUS_NO;
                        end
                        else if (ext_prev)
                        begin
                            verdict_next = isms_pkg::STATUS_OK;
                            member_next  = member_reg + 33'd1;
                            ram_we       = 1'b1;
                            ram_waddr    = p_dec[AW-1:0];
                            if (ext_next)
                            begin
                                // value bridges two intervals: merge, drop entry p
                                ram_wdata.lo = prev_reg.lo;
                                ram_wdata.hi = next_reg.hi;
                                moves_next   = count_reg - a_reg - CW'(1);
                                src_next     = a_reg + CW'(1);
                                dir_up_next  = 1'b0;
                                count_next   = count_reg - CW'(1);
                                state_next   = isms_pkg::S_SHIFT;
                            end
                            else
                            begin
                                ram_wdata.lo = prev_reg.lo;
                                ram_wdata.hi = x_reg;
                            end
                        end
                        else if (ext_next)
                        begin
                            verdict_next = isms_pkg::STATUS_OK;
                            member_next  = member_reg + 33'd1;
                            ram_we       = 1'b1;
                            ram_waddr    = a_reg[AW-1:0];
                            ram_wdata.lo = x_reg;
                            ram_wdata.hi = next_reg.hi;
                        end
                        else if (full)
                        begin
                            verdict_next = isms_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // new one-value interval at p
                            verdict_next      = isms_pkg::STATUS_OK;
                            member_next       = member_reg + 33'd1;
                            late_we_next      = 1'b1;
                            late_data_next.lo = x_reg;
                            late_data_next.hi = x_reg;
                            moves_next        = count_reg - a_reg;
                            src_next          = count_reg - CW'(1);
                            dir_up_next       = 1'b1;
                            count_next        = count_reg + CW'(1);
                            state_next        = isms_pkg::S_SHIFT;
                        end
                    end

                    isms_pkg::OP_ERASE:
                    begin
                        priority if (!in_prev)
                        begin
                            verdict_next = isms_pkg::STATUS_NO;
                        end
                        else if (prev_reg.hi == x_reg)
                        begin
                            verdict_next = isms_pkg::STATUS_OK;
                            member_next  = member_reg - 33'd1;
                            if (prev_reg.lo == x_reg)
                            begin
                                // interval empties: drop entry p-1
                                moves_next  = count_reg - a_reg;
                                src_next    = a_reg;
                                dir_up_next = 1'b0;
                                count_next  = count_reg - CW'(1);
                                state_next  = isms_pkg::S_SHIFT;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = p_dec[AW-1:0];
                                ram_wdata.lo = prev_reg.lo;
                                ram_wdata.hi = x_dec;
                            end
                        end
                        else if (prev_reg.lo == x_reg)
                        begin
                            verdict_next = isms_pkg::STATUS_OK;
                            member_next  = member_reg - 33'd1;
                            ram_we       = 1'b1;
                            ram_waddr    = p_dec[AW-1:0];
                            ram_wdata.lo = x_inc;
                            ram_wdata.hi = prev_reg.hi;
                        end
                        else if (full)
                        begin
                            verdict_next = isms_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // split: lower part stays at p-1, upper part goes to p
                            verdict_next      = isms_pkg::STATUS_OK;
                            member_next       = member_reg - 33'd1;
                            ram_we            = 1'b1;
                            ram_waddr         = p_dec[AW-1:0];
                            ram_wdata.lo      = prev_reg.lo;
                            ram_wdata.hi      = x_dec;
                            late_we_next      = 1'b1;
                            late_data_next.lo = x_inc;
                            late_data_next.hi = prev_reg.hi;
                            moves_next        = count_reg - a_reg;
                            src_next          = count_reg - CW'(1);
                            dir_up_next       = 1'b1;
                            count_next        = count_reg + CW'(1);
                            state_next        = isms_pkg::S_SHIFT;
                        end
                    end

                    default:
                    begin
                        verdict_next = in_prev ? isms_pkg::STATUS_OK : isms_pkg::STATUS_NO;
                    end
                endcase
            end

            // move one entry per cycle: read the source, write it
            // in the next cycle to its neighbor slot
            isms_pkg::S_SHIFT:
            begin
                ram_we    = pend_reg;
                ram_waddr = pend_dst_reg;
                ram_wdata = rd_entry;
                if (moves_reg != '0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = src_reg[AW-1:0];
                    pend_next  = 1'b1;
                    moves_next = moves_reg - CW'(1);
                    if (dir_up_reg)
                    begin
                        pend_dst_next = AW'(src_reg + CW'(1));
                        src_next      = src_reg - CW'(1);
                    end
                    else
                    begin
                        pend_dst_next = AW'(src_reg - CW'(1));
                        src_next      = src_reg + CW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = isms_pkg::S_FIX;
                end
            end

            // write the new entry, if any, after the range has moved up
            isms_pkg::S_FIX:
            begin
                ram_we     = late_we_reg;
                ram_waddr  = late_addr_reg;
                ram_wdata  = late_data_reg;
                state_next = isms_pkg::S_REPLY;
            end

            // hold until the output register is free
            isms_pkg::S_REPLY:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = verdict_reg;
                    out_member_next = member_reg;
                    out_count_next  = 7'(count_reg);
                    state_next      = isms_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = isms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isms_pkg::S_IDLE;
            count_reg     <= '0;
            member_reg    <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            late_we_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            member_reg    <= member_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            late_we_reg   <= late_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        x_reg          <= x_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        mid_reg        <= mid_next;
        prev_reg       <= prev_next;
        next_reg       <= next_next;
        have_prev_reg  <= have_prev_next;
        have_next_reg  <= have_next_next;
        src_reg        <= src_next;
        moves_reg      <= moves_next;
        dir_up_reg     <= dir_up_next;
        pend_dst_reg   <= pend_dst_next;
        late_addr_reg  <= late_addr_next;
        late_data_reg  <= late_data_next;
        verdict_reg    <= verdict_next;
        status_reg     <= status_next;
        out_member_reg <= out_member_next;
        out_count_reg  <= out_count_next;
    end

    // table never holds more intervals than it has entries
    `ISMS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_INTERVALS))

    // search window stays inside the stored intervals
    `ISMS_ASSERT_IMPLY(a_search_window,
        state_reg == isms_pkg::S_SEARCH, (a_reg <= b_reg) && (b_reg <= count_reg))

    // a shift write never lands on the entry being read in the same cycle
    `ISMS_ASSERT_IMPLY(a_ram_no_overlap, ram_we && ram_re, ram_waddr != ram_raddr)

    // member count changes only when an update is decided
    `ISMS_ASSERT_NEXT(a_member_hold,
        state_reg != isms_pkg::S_DECIDE, $stable(member_reg))

endmodule

`default_nettype wire

/* verif/testbench.sv */
// testbench for the interval set table: set mirror, reply checks and random traffic
`timescale 1ns / 1ps

module testbench;

    // table depth used for both the block and the mirror
    localparam int TABLE_DEPTH = 64;
    // operation code with no function of its own, behaves as a query
    localparam logic [1:0] OP_SPARE = 2'd3;
    // limit on the whole run, the slowest item plus both idle draws, taken several times over
    localparam int CYCLE_LIMIT = 1000000;
    // quiet time after the last reply, about one slow item
    localparam int TAIL_CYCLES = 100;

    // expected reply of one request item
    typedef struct {
        isms_pkg::status_t status;
        logic [32:0]       member_total;
        logic [6:0]        interval_total;
    } answer_t;

    // mirror of the sorted interval set and the queue of answers it predicts
    class membership_scoreboard;
        longint      lo_tab [TABLE_DEPTH];
        longint      hi_tab [TABLE_DEPTH];
        int          n_iv;
        logic [32:0] n_members;
        answer_t     answer_q [$];
        int          failures;

        function new();
            n_iv      = 0;
            n_members = '0;
            failures  = 0;
        endfunction

        // number of stored intervals whose lo is at or below x
        function int count_le(longint x);
            int a;
            int b;
            int mid;
            a = 0;
            b = n_iv;
            while (a < b)
            begin
                mid = a + (b - a) / 2;
                if (lo_tab[mid] <= x)
                    a = mid + 1;
                else
                    b = mid;
            end
            return a;
        endfunction

        function void drop_entry(int k);
            for (int i = k; i < n_iv - 1; i++)
            begin
                lo_tab[i] = lo_tab[i + 1];
                hi_tab[i] = hi_tab[i + 1];
            end
            n_iv--;
        endfunction

        function void open_entry(int k, longint lo, longint hi);
            for (int i = n_iv; i > k; i--)
            begin
                lo_tab[i] = lo_tab[i - 1];
                hi_tab[i] = hi_tab[i - 1];
            end
            lo_tab[k] = lo;
            hi_tab[k] = hi;
            n_iv++;
        endfunction

        function isms_pkg::status_t add_value(longint x);
            int p;
            p = count_le(x);
            if (p > 0 && hi_tab[p - 1] >= x)
                return isms_pkg::STATUS_NO;
            if (p > 0 && hi_tab[p - 1] == x - 1)
            begin
                hi_tab[p - 1] = x;
                // bridge into the next interval
                if (p < n_iv && lo_tab[p] == x + 1)
                begin
                    hi_tab[p - 1] = hi_tab[p];
                    drop_entry(p);
                end
            end
            else if (p < n_iv && lo_tab[p] == x + 1)
                lo_tab[p] = x;
            else
            begin
                if (n_iv >= TABLE_DEPTH)
                    return isms_pkg::STATUS_FULL;
                open_entry(p, x, x);
            end
            n_members++;
            return isms_pkg::STATUS_OK;
        endfunction

        function isms_pkg::status_t remove_value(longint x);
            int p;
            int k;
            p = count_le(x);
            if (p == 0 || hi_tab[p - 1] < x)
                return isms_pkg::STATUS_NO;
            k = p - 1;
            if (hi_tab[k] == x)
            begin
                hi_tab[k] = x - 1;
                if (lo_tab[k] > hi_tab[k])
                    drop_entry(k);
            end
            else if (lo_tab[k] == x)
                lo_tab[k] = x + 1;
            else
            begin
                // split needs a free slot
                if (n_iv >= TABLE_DEPTH)
                    return isms_pkg::STATUS_FULL;
                open_entry(p, x + 1, hi_tab[k]);
                hi_tab[k] = x - 1;
            end
            n_members--;
            return isms_pkg::STATUS_OK;
        endfunction

        function void note_request(logic [1:0] op, logic signed [31:0] value);
            longint  x;
            int      p;
            answer_t ans;
            x = value;
            if (op == isms_pkg::OP_INSERT)
                ans.status = add_value(x);
            else if (op == isms_pkg::OP_ERASE)
                ans.status = remove_value(x);
            else
            begin
                p = count_le(x);
                ans.status = (p > 0 && hi_tab[p - 1] >= x) ? isms_pkg::STATUS_OK
                                                            : isms_pkg::STATUS_NO;
            end
            ans.member_total   = n_members;
            ans.interval_total = n_iv[6:0];
            answer_q = {answer_q, ans};
        endfunction

        function void check_reply(isms_pkg::status_t status, logic [32:0] member_total,
                                  logic [6:0] interval_total);
            answer_t ans;
            if (answer_q.size() == 0)
            begin
                $error("reply with no request waiting: status %0d", status);
                failures++;
                return;
            end
            ans = answer_q.pop_front();
            if (status !== ans.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", ans.status, status);
                failures++;
            end
            if (member_total !== ans.member_total)
            begin
                $error("member_total mismatch: expected %0d, actual %0d",
                       ans.member_total, member_total);
                failures++;
            end
            if (interval_total !== ans.interval_total)
            begin
                $error("interval_total mismatch: expected %0d, actual %0d",
                       ans.interval_total, interval_total);
                failures++;
            end
        endfunction

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    // when set, neither side idles
    bit   quiet = 1'b0;
    int   cycle_count = 0;

    membership_scoreboard ledger = new();

    isms_req_if request_ch();
    isms_rsp_if response_ch();

    interval_set_membership_table #(
        .MAX_INTERVALS(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch.sink),
        .response (response_ch.source)
    );

    always #6 clk = ~clk;

    // present one item after a random gap and hold it until the block takes it
    // valid is left high after the accept so a zero gap does not drop it
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.operation <= op;
        request_ch.value     <= value;
        do
            @(posedge clk);
        while (!request_ch.ready);
        ledger.note_request(op, value);
    endtask

    // hold off the sender until every outstanding reply is back
    task automatic wait_drained();
        request_ch.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    // weighted operation: mostly updates, some queries, a few spare codes
    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return isms_pkg::OP_INSERT;
        else if (r < 80)
            return isms_pkg::OP_ERASE;
        else if (r < 95)
            return isms_pkg::OP_QUERY;
        return OP_SPARE;
    endfunction

    // sender process with the reset sequence
    initial
    begin
        logic signed [31:0] base;
        logic signed [31:0] anchor;
        int                 k;

        request_ch.valid     <= 1'b0;
        request_ch.operation <= isms_pkg::OP_QUERY;
        request_ch.value     <= '0;
        rst_n                <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty set, both extremes, merges, splits, spare code
        send_item(isms_pkg::OP_QUERY, 32'sd0);
        send_item(isms_pkg::OP_ERASE, 32'sd5);
        send_item(isms_pkg::OP_INSERT, isms_pkg::VALUE_MIN);
        send_item(isms_pkg::OP_INSERT, isms_pkg::VALUE_MAX);
        send_item(isms_pkg::OP_INSERT, isms_pkg::VALUE_MIN + 32'sd1);
        send_item(isms_pkg::OP_INSERT, isms_pkg::VALUE_MAX - 32'sd1);
        send_item(isms_pkg::OP_QUERY, isms_pkg::VALUE_MIN);
        send_item(OP_SPARE, isms_pkg::VALUE_MAX);
        send_item(isms_pkg::OP_INSERT, 32'sd10);
        send_item(isms_pkg::OP_INSERT, 32'sd12);
        // bridge two single values into one interval
        send_item(isms_pkg::OP_INSERT, 32'sd11);
        send_item(isms_pkg::OP_INSERT, 32'sd11);
        // split in the middle, then drop the singles
        send_item(isms_pkg::OP_ERASE, 32'sd11);
        send_item(isms_pkg::OP_ERASE, 32'sd10);
        send_item(isms_pkg::OP_ERASE, 32'sd12);
        // shrink at the low end and the high end of the extreme intervals
        send_item(isms_pkg::OP_ERASE, isms_pkg::VALUE_MIN);
        send_item(isms_pkg::OP_ERASE, isms_pkg::VALUE_MAX);
        send_item(isms_pkg::OP_ERASE, isms_pkg::VALUE_MAX - 32'sd1);
        send_item(isms_pkg::OP_INSERT, -32'sd1);
        send_item(isms_pkg::OP_INSERT, 32'sd0);
        send_item(isms_pkg::OP_INSERT, 32'sd1);
        send_item(isms_pkg::OP_ERASE, 32'sd0);
        send_item(isms_pkg::OP_QUERY, 32'sd0);
        send_item(OP_SPARE, -32'sd1);
        wait_drained();

        // dense window: lots of merges, shrinks and splits
        base = -32'sd24;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 50 == 49)
                base = $urandom;
            send_item(pick_op(), base + $urandom_range(0, 47));
        end
        wait_drained();

        // fill the table with singles four apart until inserts are refused
        base = $urandom;
        for (k = 0; k < 68; k++)
            send_item(isms_pkg::OP_INSERT, base + 4 * k);
        // widen singles, then try splits while the table is full
        for (int i = 0; i < 100; i++)
            send_item(isms_pkg::OP_INSERT,
                      base + 4 * $urandom_range(0, 67) + $urandom_range(1, 2));
        for (int i = 0; i < 60; i++)
        begin
            k = $urandom_range(0, 67);
            case ($urandom_range(0, 3))
                0: send_item(isms_pkg::OP_INSERT, base + 4 * k + 3);
                1: send_item(isms_pkg::OP_QUERY, base + 4 * k + $urandom_range(0, 3));
                default: send_item(isms_pkg::OP_ERASE, base + 4 * k + 1);
            endcase
        end
        wait_drained();
        // sweep the fill window empty again
        for (k = 0; k < 4 * 68 + 3; k++)
            send_item(isms_pkg::OP_ERASE, base + k);
        wait_drained();

        // full range values, clustered around moving anchors
        anchor = $urandom;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 16 == 15)
                anchor = $urandom;
            if ($urandom_range(0, 1))
                send_item(2'($urandom_range(0, 3)), $urandom);
            else
                send_item(pick_op(), anchor + $urandom_range(0, 7));
        end

        // edges of the value range, no wrap across them
        for (int i = 0; i < 150; i++)
        begin
            if ($urandom_range(0, 1))
                send_item(pick_op(), isms_pkg::VALUE_MIN + $urandom_range(0, 15));
            else
                send_item(pick_op(), isms_pkg::VALUE_MAX - $urandom_range(0, 15));
        end

        // back to back traffic with no idling on either side
        quiet = 1'b1;
        base  = $urandom;
        for (int i = 0; i < 100; i++)
            send_item(pick_op(), base + $urandom_range(0, 31));
        quiet = 1'b0;

        // let the last replies come home, then a quiet tail
        request_ch.valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, check every reply taken
    initial
    begin
        int stall;
        response_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!response_ch.valid);
            ledger.check_reply(response_ch.status, response_ch.member_total,
                               response_ch.interval_total);
        end
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
